### rtl/glr_pkg.sv
`default_nettype none
package glr_pkg;

  // register map, word index taken from paddr[3:2]
  localparam int unsigned CfgAddrW = 4;
  localparam logic [1:0] REG_SPRITE_FORMAT = 2'd0;
  localparam logic [1:0] REG_GLYPH_WIDTH   = 2'd1;
  localparam logic [1:0] REG_GLYPH_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_RANGES_IN_USE = 2'd3;

  // register reset values
  localparam logic       SpriteFormatRst = 1'b0;
  localparam logic [7:0] GlyphWidthRst   = 8'd8;
  localparam logic [7:0] GlyphHeightRst  = 8'd8;
  localparam logic [6:0] RangesInUseRst  = 7'd0;

  // input operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // sprite formats
  localparam logic FMT_NATIVE     = 1'b0;
  localparam logic FMT_HORIZONTAL = 1'b1;

  localparam int unsigned RangeDepthDefault = 64;

  // field widths
  localparam int unsigned CodeW   = 16;
  localparam int unsigned BaseW   = 24;
  localparam int unsigned BytesW  = 13;
  localparam int unsigned ProdW   = CodeW + BytesW;
  localparam int unsigned OffsetW = 32;

  // one range table entry
  typedef struct packed {
    logic [CodeW-1:0] first;
    logic [CodeW-1:0] last;
    logic [BaseW-1:0] base;
  } range_entry_t;

  // search sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_MUL,
    S_ADD,
    S_OUT
  } glr_state_e;

endpackage
`default_nettype wire

### rtl/glyph_range_lookup.sv
// glyph_range_lookup: turns a character code into the byte offset of its glyph bitmap.
// Input channel (in_valid_i / in_stall_o) carries one word: either a table write
// (operation 0: slot, first code, last code, byte offset) or a lookup (operation 1:
// char_code). A write completes at the accepting edge and gives no result word.
// A lookup gives one result word (found, glyph_offset, overflow) on the output
// channel (out_valid_o / out_stall_i).
// A lookup binary-searches the first ranges_in_use slots (at most RANGE_DEPTH); each
// probe addresses the table memory in S_PROBE, then compares on the registered read
// data in S_CMP. A hit then passes a multiply state and an add state before S_OUT; a
// miss goes from S_PROBE to S_OUT once the search window is empty. One lookup is in
// flight at a time; in_stall_o is high until the result has been moved into the
// output register, so no new word is taken before the last lookup is through.
// Writes can follow back to back.
// The output register holds its word while out_stall_i is high; a finished lookup
// then waits in the sequencer and the input stays stalled.
// Reset clears the sequencer, the output valid and the registers to their defaults
// (native format, 8x8 glyphs, no ranges in use). Table contents are undefined
// until written. The user must write the registers over the APB port only while idle;
// the block itself has no check for this.
`default_nettype none
module glyph_range_lookup
  import glr_pkg::*;
#(
  parameter int unsigned RANGE_DEPTH = RangeDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                operation_i,
  input  wire logic [5:0]          entry_index_i,
  input  wire logic [15:0]         range_first_i,
  input  wire logic [15:0]         range_last_i,
  input  wire logic [23:0]         range_byte_offset_i,
  input  wire logic [15:0]         char_code_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     found_o,
  output logic [31:0]              glyph_offset_o,
  output logic                     overflow_o
);

  localparam int unsigned IdxW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RANGE_DEPTH + 1);

  // configuration registers
  logic       sprite_format_q;
  logic [7:0] glyph_width_q;
  logic [7:0] glyph_height_q;
  logic [6:0] ranges_in_use_q;
  logic       cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sprite_format_q <= SpriteFormatRst;
      glyph_width_q   <= GlyphWidthRst;
      glyph_height_q  <= GlyphHeightRst;
      ranges_in_use_q <= RangesInUseRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SPRITE_FORMAT: sprite_format_q <= pwdata[0];
        REG_GLYPH_WIDTH:   glyph_width_q   <= pwdata[7:0];
        REG_GLYPH_HEIGHT:  glyph_height_q  <= pwdata[7:0];
        REG_RANGES_IN_USE: ranges_in_use_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_SPRITE_FORMAT: prdata = {31'd0, sprite_format_q};
      REG_GLYPH_WIDTH:   prdata = {24'd0, glyph_width_q};
      REG_GLYPH_HEIGHT:  prdata = {24'd0, glyph_height_q};
      REG_RANGES_IN_USE: prdata = {25'd0, ranges_in_use_q};
      default:           prdata = 32'd0;
    endcase
  end

  // glyph size in bytes, registered off the config path
  logic [4:0]        cells;
  logic [7:0]        span;
  logic [BytesW-1:0] bytes_q;

  always_comb begin
    if (sprite_format_q == FMT_HORIZONTAL) begin
      cells = glyph_width_q[7:3];
      span  = glyph_height_q;
    end else begin
      cells = glyph_height_q[7:3];
      span  = glyph_width_q;
    end
    if (cells == 5'd0) begin
      cells = 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= BytesW'(cells) * BytesW'(span);
  end

  // sequencer state
  glr_state_e state_q, state_d;
  logic       in_acc;
  logic       out_free;
  logic       hit;
  logic       code_lt;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_free = ~out_valid_o | ~out_stall_i;

  // search window [lo, hi) and probe index
  logic [CntW-1:0] lo_q, hi_q, mid_q;
  logic [CntW-1:0] mid;
  logic [CntW:0]   mid_sum;

  assign mid_sum = (CntW + 1)'(lo_q) + (CntW + 1)'(hi_q) - (CntW + 1)'(1);
  assign mid     = mid_sum[CntW:1];

  // range table
  range_entry_t table_mem [RANGE_DEPTH];
  range_entry_t rd_q;
  logic         tbl_wr;
  logic         tbl_rd;

  always_ff @(posedge clk_i) begin
    if (tbl_wr) begin
      table_mem[IdxW'(entry_index_i)] <= '{first: range_first_i,
                                          last:  range_last_i,
                                          base:  range_byte_offset_i};
    end
    if (tbl_rd) begin
      rd_q <= table_mem[mid[IdxW-1:0]];
    end
  end

  // probe compare
  logic [CodeW-1:0] code_q;

  assign hit     = (code_q >= rd_q.first) && (code_q <= rd_q.last);
  assign code_lt = code_q < rd_q.first;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && operation_i == OP_LOOKUP) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          state_d = S_CMP;
        end else begin
          state_d = S_OUT;
        end
      end
      S_CMP: begin
        if (hit) begin
          state_d = S_MUL;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_MUL: state_d = S_ADD;
      S_ADD: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    tbl_wr     = 1'b0;
    tbl_rd     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        tbl_wr     = in_valid_i && operation_i == OP_WRITE &&
                     int'(entry_index_i) < RANGE_DEPTH;
      end
      S_PROBE: tbl_rd = lo_q < hi_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // search window update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      hi_q  <= '0;
      mid_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            lo_q <= '0;
            if (int'(ranges_in_use_q) > RANGE_DEPTH) begin
              hi_q <= CntW'(RANGE_DEPTH);
            end else begin
              hi_q <= CntW'(ranges_in_use_q);
            end
          end
        end
        S_PROBE: mid_q <= mid;
        S_CMP: begin
          if (!hit) begin
            if (code_lt) begin
              hi_q <= mid_q;
            end else begin
              lo_q <= mid_q + CntW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // offset datapath: diff, multiply, add with saturation
  logic [CodeW-1:0] diff_q;
  logic [BaseW-1:0] base_q;
  logic [ProdW-1:0] prod_q;
  logic             found_q;
  logic [OffsetW:0] sum;

  assign sum = (OffsetW + 1)'(base_q) + (OffsetW + 1)'(prod_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      code_q <= char_code_i;
    end
    unique case (state_q)
      S_IDLE:  found_q <= 1'b0;
      S_CMP: begin
        if (hit) begin
          diff_q  <= code_q - rd_q.first;
          base_q  <= rd_q.base;
          found_q <= 1'b1;
        end
      end
      S_MUL:   prod_q <= ProdW'(diff_q) * ProdW'(bytes_q);
      default: ;
    endcase
  end

  logic [OffsetW-1:0] offs_q;
  logic               ovf_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      offs_q <= '0;
      ovf_q  <= 1'b0;
    end else if (state_q == S_ADD) begin
      if (sum[OffsetW]) begin
        offs_q <= '1;
        ovf_q  <= 1'b1;
      end else begin
        offs_q <= sum[OffsetW-1:0];
        ovf_q  <= 1'b0;
      end
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      found_o        <= found_q;
      glyph_offset_o <= offs_q;
      overflow_o     <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // a miss carries a zero offset and no overflow
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> glyph_offset_o == '0 && !overflow_o)
    else $error("miss with nonzero offset or overflow");

  // saturation only with the all-ones offset
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> found_o && glyph_offset_o == '1)
    else $error("overflow without saturated offset");

  // search window stays ordered and inside the table
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q && int'(hi_q) <= RANGE_DEPTH)
    else $error("search window out of order");

  // a table write produces no result word
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && operation_i == OP_WRITE |=> !$rose(out_valid_o))
    else $error("result word after table write");

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench
  import glr_pkg::*;
();

  localparam int unsigned Depth      = RangeDepthDefault;
  localparam int unsigned TailWords  = 470;
  localparam int unsigned TotalWords = 550;
  localparam int unsigned SettleCyc  = 24;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic        overflow;
  } glyph_result_t;

  // dut ports
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                operation_i;
  logic [5:0]          entry_index_i;
  logic [15:0]         range_first_i;
  logic [15:0]         range_last_i;
  logic [23:0]         range_byte_offset_i;
  logic [15:0]         char_code_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                found_o;
  logic [31:0]         glyph_offset_o;
  logic                overflow_o;

  // predictor copy of the range table and registers
  logic [15:0]   tbl_first [Depth];
  logic [15:0]   tbl_last  [Depth];
  logic [23:0]   tbl_base  [Depth];
  bit            tbl_written [Depth];
  int            slots_written;
  logic          cfg_format;
  logic [7:0]    cfg_width;
  logic [7:0]    cfg_height;
  logic [6:0]    cfg_count;

  glyph_result_t pending_glyphs[$];
  glyph_result_t want;
  int            errors = 0;
  int            words_sent;
  bit            idle_on;
  int            stall_left = 0;

  glyph_range_lookup dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .entry_index_i      (entry_index_i),
    .range_first_i      (range_first_i),
    .range_last_i       (range_last_i),
    .range_byte_offset_i(range_byte_offset_i),
    .char_code_i        (char_code_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .found_o            (found_o),
    .glyph_offset_o     (glyph_offset_o),
    .overflow_o         (overflow_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // expected glyph address for a lookup, binary search over the table copy
  function automatic glyph_result_t glyph_address(input logic [15:0] code);
    glyph_result_t r;
    logic [63:0]   cells;
    logic [63:0]   glyph_sz;
    logic [63:0]   sum;
    int            lo;
    int            hi;
    int            mid;
    r = '{found: 1'b0, offset: 32'd0, overflow: 1'b0};
    if (cfg_format == FMT_HORIZONTAL) begin
      cells = 64'(cfg_width / 8);
      if (cells == 0) cells = 1;
      glyph_sz = cells * 64'(cfg_height);
    end else begin
      cells = 64'(cfg_height / 8);
      if (cells == 0) cells = 1;
      glyph_sz = cells * 64'(cfg_width);
    end
    lo = 0;
    hi = ((cfg_count > Depth) ? Depth : int'(cfg_count)) - 1;
    while (lo <= hi && !r.found) begin
      mid = lo + (hi - lo) / 2;
      if (code >= tbl_first[mid] && code <= tbl_last[mid]) begin
        sum = 64'(tbl_base[mid]) + 64'(code - tbl_first[mid]) * glyph_sz;
        r.found = 1'b1;
        if (sum > 64'hFFFF_FFFF) begin
          sum = 64'hFFFF_FFFF;
          r.overflow = 1'b1;
        end
        r.offset = sum[31:0];
      end else if (code < tbl_first[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  // lookup code: mostly at or around a stored range, sometimes anywhere
  function automatic logic [15:0] pick_code(input int n);
    int          s;
    logic [15:0] f;
    logic [15:0] l;
    if (n == 0 || $urandom_range(0, 4) == 0) return 16'($urandom);
    s = $urandom_range(0, n - 1);
    f = tbl_first[s];
    l = tbl_last[s];
    case ($urandom_range(0, 4))
      0: return f;
      1: return l;
      2: return f - 16'd1;
      3: return l + 16'd1;
      default: return (l >= f) ? f + 16'($urandom_range(0, l - f)) : f;
    endcase
  endfunction

  function automatic logic [7:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd7;
      3: return 8'd8;
      4: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // send one word on the input channel and update the prediction on acceptance
  task automatic send_word(input logic op, input logic [5:0] idx, input logic [15:0] first,
                           input logic [15:0] last, input logic [23:0] base,
                           input logic [15:0] code);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    // fields that the operation ignores carry junk
    if (op == OP_WRITE) begin
      code = 16'($urandom);
    end else begin
      idx   = 6'($urandom);
      first = 16'($urandom);
      last  = 16'($urandom);
      base  = 24'($urandom);
    end
    in_valid_i          <= 1'b1;
    operation_i         <= op;
    entry_index_i       <= idx;
    range_first_i       <= first;
    range_last_i        <= last;
    range_byte_offset_i <= base;
    char_code_i         <= code;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_WRITE) begin
      tbl_first[idx] = first;
      tbl_last[idx]  = last;
      tbl_base[idx]  = base;
      if (!tbl_written[idx]) begin
        tbl_written[idx] = 1'b1;
        slots_written++;
      end
    end else begin
      pending_glyphs.push_back(glyph_address(code));
    end
    words_sent++;
  endtask

  task automatic write_range(input logic [5:0] idx, input logic [15:0] first,
                             input logic [15:0] last, input logic [23:0] base);
    send_word(OP_WRITE, idx, first, last, base, 16'd0);
  endtask

  task automatic look_up(input logic [15:0] code);
    send_word(OP_LOOKUP, 6'd0, 16'd0, 16'd0, 24'd0, code);
  endtask

  // drop valid, let every result come back and the sequencer settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // apb register write, upper bits sometimes filled with junk
  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value, input int w);
    logic [31:0] data;
    data = value;
    if ($urandom_range(0, 1) == 1) data = data | ($urandom << w);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (reg_idx)
      REG_SPRITE_FORMAT: cfg_format = data[0];
      REG_GLYPH_WIDTH:   cfg_width  = data[7:0];
      REG_GLYPH_HEIGHT:  cfg_height = data[7:0];
      REG_RANGES_IN_USE: cfg_count  = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random glyph layout plus the given range count
  task automatic set_layout(input int count);
    wait_idle();
    apb_write(REG_SPRITE_FORMAT, 32'($urandom_range(0, 1)), 1);
    apb_write(REG_GLYPH_WIDTH, 32'(pick_dim()), 8);
    apb_write(REG_GLYPH_HEIGHT, 32'(pick_dim()), 8);
    apb_write(REG_RANGES_IN_USE, 32'(count), 7);
  endtask

  // write n sorted, disjoint ranges into slots 0..n-1
  task automatic fill_sorted(input int n);
    int          span;
    int          i;
    int          slot;
    bit          reverse;
    bit          edges;
    logic [15:0] first;
    logic [15:0] last;
    if (n == 0) return;
    span    = 65536 / n;
    reverse = $urandom_range(0, 1);
    edges   = ($urandom_range(0, 4) == 0);
    for (i = 0; i < n; i++) begin
      slot  = reverse ? n - 1 - i : i;
      first = 16'(slot * span + $urandom_range(0, span / 2));
      if ($urandom_range(0, 3) == 0) last = first;
      else last = first + 16'($urandom_range(0, span / 2 - 1));
      if (edges && slot == 0) first = 16'd0;
      if (edges && slot == n - 1) last = 16'hFFFF;
      write_range(6'(slot), first, last, 24'($urandom));
    end
  endtask

  task automatic test_directed_edges();
    // empty table: every lookup misses
    look_up(16'h0000);
    look_up(16'hFFFF);
    write_range(6'd0, 16'd0, 16'd15, 24'd0);
    write_range(6'd1, 16'd100, 16'd200, 24'hFFFFFF);
    // first above last never hits
    write_range(6'd2, 16'd300, 16'd299, 24'h001234);
    write_range(6'd3, 16'd1000, 16'hFFFF, 24'hABCDEF);
    write_range(6'd63, 16'hFFFF, 16'hFFFF, 24'h555555);
    wait_idle();
    apb_write(REG_RANGES_IN_USE, 32'd4, 7);
    look_up(16'd0);
    look_up(16'd15);
    look_up(16'd16);
    look_up(16'd100);
    look_up(16'd200);
    look_up(16'd299);
    look_up(16'd300);
    look_up(16'd1000);
    look_up(16'hFFFF);
    // largest glyph, largest code
    wait_idle();
    apb_write(REG_SPRITE_FORMAT, 32'(FMT_HORIZONTAL), 1);
    apb_write(REG_GLYPH_WIDTH, 32'd255, 8);
    apb_write(REG_GLYPH_HEIGHT, 32'd255, 8);
    look_up(16'hFFFF);
    // zero sized glyph returns the range base
    wait_idle();
    apb_write(REG_GLYPH_WIDTH, 32'd0, 8);
    apb_write(REG_GLYPH_HEIGHT, 32'd0, 8);
    look_up(16'd150);
    // narrow glyphs round up to one byte column or row
    wait_idle();
    apb_write(REG_SPRITE_FORMAT, 32'(FMT_NATIVE), 1);
    apb_write(REG_GLYPH_WIDTH, 32'd9, 8);
    apb_write(REG_GLYPH_HEIGHT, 32'd7, 8);
    look_up(16'd1234);
    wait_idle();
    apb_write(REG_SPRITE_FORMAT, 32'(FMT_HORIZONTAL), 1);
    apb_write(REG_GLYPH_WIDTH, 32'd7, 8);
    apb_write(REG_GLYPH_HEIGHT, 32'd9, 8);
    look_up(16'd120);
  endtask

  task automatic test_sorted_tables();
    int n;
    int m;
    case ($urandom_range(0, 9)) inside
      0: n = 0;
      1, 2: n = $urandom_range(9, 32);
      default: n = $urandom_range(1, 8);
    endcase
    set_layout(n);
    fill_sorted(n);
    m = $urandom_range(8, 20);
    repeat (m) look_up(pick_code(n));
  endtask

  // all 64 slots sorted, count at and above the table depth
  task automatic test_full_table();
    int count;
    count = ($urandom_range(0, 2) == 0) ? Depth : $urandom_range(Depth, 127);
    set_layout(count);
    fill_sorted(Depth);
    repeat (20) look_up(pick_code(Depth));
  endtask

  // unsorted contents, empty ranges, writes mixed into the lookups
  task automatic test_broken_tables();
    int k;
    int count;
    int i;
    k = $urandom_range(0, 12);
    if (slots_written == Depth && $urandom_range(0, 2) == 0) count = $urandom_range(0, 127);
    else count = $urandom_range(0, k);
    set_layout(count);
    for (i = 0; i < k; i++) begin
      write_range(6'(i), 16'($urandom), 16'($urandom), 24'($urandom));
    end
    repeat ($urandom_range(8, 16)) begin
      if ($urandom_range(0, 4) == 0) begin
        write_range(6'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
      end else begin
        look_up(pick_code(k));
      end
    end
  endtask

  // no idling on either side to the end
  task automatic test_unpaced_tail();
    idle_on = 1'b0;
    while (words_sent < TotalWords) test_sorted_tables();
  endtask

  // output stall in random bursts while idle_on is set
  always @(negedge clk_i) begin
    if (!idle_on) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result check against the oldest expected glyph
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_glyphs.size() == 0) begin
        $error("result word with no lookup pending");
        errors++;
      end else begin
        want = pending_glyphs.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          errors++;
        end
        if (glyph_offset_o !== want.offset) begin
          $error("glyph_offset: expected 0x%08h, got 0x%08h", want.offset, glyph_offset_o);
          errors++;
        end
        if (overflow_o !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, overflow_o);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_valid_i          = 1'b0;
    operation_i         = OP_WRITE;
    entry_index_i       = '0;
    range_first_i       = '0;
    range_last_i        = '0;
    range_byte_offset_i = '0;
    char_code_i         = '0;
    idle_on             = 1'b1;
    words_sent          = 0;
    slots_written       = 0;
    cfg_format          = SpriteFormatRst;
    cfg_width           = GlyphWidthRst;
    cfg_height          = GlyphHeightRst;
    cfg_count           = RangesInUseRst;
    for (int i = 0; i < Depth; i++) begin
      tbl_first[i]   = '0;
      tbl_last[i]    = '0;
      tbl_base[i]    = '0;
      tbl_written[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    idle_on = 1'b1;
    test_full_table();
    while (words_sent < TailWords) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 11)) inside
        0, 1: test_broken_tables();
        2: test_full_table();
        default: test_sorted_tables();
      endcase
    end
    test_unpaced_tail();

    // drain and settle
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/glr_pkg.sv
rtl/glyph_range_lookup.sv
bench/testbench.sv
